@@ rtl/assn_pkg.sv @@
package assn_pkg;

    localparam int MAX_PARTIALS = 6;
    localparam int PHASE_BITS   = 32;
    localparam int AMP_BITS     = 10;
    localparam int SUM_BITS     = 20;
    localparam int ACC_BITS     = 29;
    localparam int QTR_DEPTH    = 256;
    localparam int DIV_BITS     = 37;

    localparam logic [2:0] REG_FUND_STEP = 3'd0;
    localparam logic [2:0] REG_RATIOS    = 3'd1;
    localparam logic [2:0] REG_AMPS      = 3'd2;
    localparam logic [2:0] REG_COUNT     = 3'd3;
    localparam logic [2:0] REG_PEAK      = 3'd4;

    typedef struct packed {
        logic pass_sel;
        logic restart;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               flat;
    } t_out;

    typedef logic [QTR_DEPTH-1:0][14:0] t_qtr;

    // Quarter-wave magnitude for a distance of rem quarter-steps from zero phase.
    function automatic logic [14:0] sine_mag(input logic [63:0] rem);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] mag;
        x  = (64'd1686629713 * rem) >> 8;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd156);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
        s   = (x * t) >> 30;
        mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return mag[14:0];
    endfunction

    function automatic t_qtr build_qtr();
        t_qtr tab;
        for (int i = 0; i < QTR_DEPTH; i++) begin
            tab[i] = sine_mag(64'(i));
        end
        return tab;
    endfunction

    localparam t_qtr SINE_QTR = build_qtr();
    // The quarter-wave peak sits one step past the end of the table.
    localparam logic [14:0] SINE_PEAK = sine_mag(64'(QTR_DEPTH));

endpackage

@@ rtl/additive_sine_synth_normalizer_core.sv @@
// Additive sine synthesizer with min/max normalization. Each item is one tick: a measure
// tick (pass_sel 0) regenerates the partial sum and widens min/max (a restart sets both
// to it) without a result, an emit tick (pass_sel 1) regenerates it and returns one sample
// scaled onto +-peak, or a flat zero for a zero range. One shared multiplier and a
// quarter-wave sine table serve all partials in turn: a measure restart first derives the
// phase steps of the configured partials, every tick then reads, multiplies and
// accumulates each active partial, an emit tick holds its result until it is taken, and
// an emit tick with a nonzero range adds setup and bit-serial division. The block is not
// ready while an item is in work or its result waits.
module additive_sine_synth_normalizer_core
    import assn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [59:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SMUL = 4'd1;
    localparam logic [3:0] S_SCHK = 4'd2;
    localparam logic [3:0] S_SYN  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_SCL  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]  r_state;
    logic [31:0] r_fund;
    logic [59:0] r_ratios;
    logic [59:0] r_amps;
    logic [2:0]  r_count;
    logic [14:0] r_peak;

    logic [PHASE_BITS-1:0] r_phase [MAX_PARTIALS];
    logic [PHASE_BITS-1:0] r_step  [MAX_PARTIALS];
    logic [2:0]            r_active;
    logic [2:0]            r_n;
    logic [2:0]            r_lim;
    logic                  r_emit;
    logic                  r_restart_q;
    logic signed [SUM_BITS-1:0] r_min;
    logic signed [SUM_BITS-1:0] r_max;
    logic [SUM_BITS-1:0]   r_scale;
    logic signed [ACC_BITS-1:0] r_acc;
    logic signed [15:0]    r_sine;
    logic signed [54:0]    r_prod;
    logic [20:0]           r_rem;
    logic [DIV_BITS-1:0]   r_quo;
    logic [5:0]            r_cnt;
    logic                  r_neg;
    t_out                  r_out;

    // Shared multiplier operands.
    logic signed [32:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [SUM_BITS-1:0] x_val;
    logic signed [22:0] diff;
    logic [9:0]  tab_idx;
    logic [7:0]  tab_rem;
    logic        tab_peak;
    logic [14:0] tab_mag;
    logic [41:0] full;
    logic [DIV_BITS-1:0] t_mag;
    logic [21:0] rem_sh;
    logic [21:0] rem_sub;

    assign x_val = r_acc[ACC_BITS-1:9];
    assign diff  = ((23'(x_val) - 23'(r_min)) <<< 1) - $signed({3'b000, r_scale});
    assign full  = r_prod[41:0];

    always_comb begin
        mul_a = 33'(r_sine);
        mul_b = $signed({12'd0, r_amps[10*r_n +: AMP_BITS]});
        case (r_state)
            S_SMUL: begin
                mul_a = $signed({1'b0, r_fund});
                mul_b = $signed({12'd0, r_ratios[10*r_n +: AMP_BITS]});
            end
            S_FIN: begin
                mul_a = 33'(diff);
                mul_b = $signed({7'd0, r_peak});
            end
            default: ;
        endcase
    end

    assign tab_idx  = r_phase[r_n][PHASE_BITS-1 -: 10];
    assign tab_peak = tab_idx[8] && (tab_idx[7:0] == 8'd0);
    assign tab_rem  = tab_idx[8] ? (8'd0 - tab_idx[7:0]) : tab_idx[7:0];
    assign tab_mag  = tab_peak ? SINE_PEAK : SINE_QTR[tab_rem];

    assign t_mag   = r_prod[54] ? DIV_BITS'(-r_prod) : r_prod[DIV_BITS-1:0];
    assign rem_sh  = {r_rem, r_quo[DIV_BITS-1]};
    assign rem_sub = rem_sh - {2'b00, r_scale};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_state == S_RD) begin
            r_sine <= tab_idx[9] ? -$signed({1'b0, tab_mag}) : $signed({1'b0, tab_mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fund   <= 32'd42852282;
            r_ratios <= 60'd649081777758211328;
            r_amps   <= 60'd537395712;
            r_count  <= 3'd6;
            r_peak   <= 15'd22334;
            r_active <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_scale  <= '0;
            r_n      <= '0;
            r_lim    <= '0;
            r_emit   <= 1'b0;
            for (int i = 0; i < MAX_PARTIALS; i++) begin
                r_phase[i] <= '0;
                r_step[i]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_FUND_STEP: r_fund   <= i_cfg_data[31:0];
                    REG_RATIOS:    r_ratios <= i_cfg_data;
                    REG_AMPS:      r_amps   <= i_cfg_data;
                    REG_COUNT:     r_count  <= i_cfg_data[2:0];
                    REG_PEAK:      r_peak   <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_emit <= i_in_data.pass_sel;
                        r_n    <= '0;
                        r_state <= (i_in_data.restart && !i_in_data.pass_sel &&
                                    r_count != 3'd0) ? S_SMUL : S_SYN;
                        if (i_in_data.restart) begin
                            for (int i = 0; i < MAX_PARTIALS; i++) begin
                                r_phase[i] <= '0;
                            end
                            if (i_in_data.pass_sel) begin
                                r_scale <= SUM_BITS'(r_max - r_min);
                            end else begin
                                for (int i = 0; i < MAX_PARTIALS; i++) begin
                                    r_step[i] <= '0;
                                end
                                r_active <= '0;
                                r_lim <= (r_count > 3'(MAX_PARTIALS)) ?
                                         3'(MAX_PARTIALS) : r_count;
                            end
                        end
                    end
                end
                S_SMUL: r_state <= S_SCHK;
                S_SCHK: begin
                    // A partial at or above Nyquist ends the list.
                    if (full[41:39] != 3'd0) begin
                        r_state <= S_SYN;
                    end else begin
                        r_step[r_n] <= full[39:8];
                        r_active    <= r_n + 3'd1;
                        r_n         <= r_n + 3'd1;
                        r_state     <= (r_n + 3'd1 == r_lim) ? S_SYN : S_SMUL;
                    end
                end
                S_SYN: begin
                    r_n   <= '0;
                    r_acc <= '0;
                    r_state <= (r_active == 3'd0) ? S_FIN : S_RD;
                end
                S_RD: begin
                    r_phase[r_n] <= r_phase[r_n] + r_step[r_n];
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_acc <= r_acc + r_prod[ACC_BITS-1:0];
                    r_n   <= r_n + 3'd1;
                    r_state <= (r_n + 3'd1 == r_active) ? S_FIN : S_RD;
                end
                S_FIN: begin
                    if (!r_emit) begin
                        r_state <= S_IDLE;
                    end else if (r_scale == '0) begin
                        r_out.sample <= '0;
                        r_out.flat   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SCL;
                    end
                end
                S_SCL: begin
                    r_neg <= r_prod[54];
                    r_quo <= t_mag;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 6'(DIV_BITS)) begin
                        if (r_quo > 37'd32767) begin
                            r_out.sample <= r_neg ? -16'sd32767 : 16'sd32767;
                        end else begin
                            r_out.sample <= r_neg ? -$signed(r_quo[15:0]) :
                                            $signed(r_quo[15:0]);
                        end
                        r_out.flat <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        if (!rem_sub[21]) begin
                            r_rem <= rem_sub[20:0];
                            r_quo <= {r_quo[DIV_BITS-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[20:0];
                            r_quo <= {r_quo[DIV_BITS-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Min/max tracking at the end of a measure tick.
            if (r_state == S_FIN && !r_emit) begin
                if (r_restart_q) begin
                    r_min <= x_val;
                    r_max <= x_val;
                end else begin
                    if (x_val > r_max) begin
                        r_max <= x_val;
                    end
                    if (x_val < r_min) begin
                        r_min <= x_val;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart_q <= 1'b0;
        end else if (r_state == S_IDLE && i_in_valid) begin
            r_restart_q <= i_in_data.restart;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.flat |-> o_out_data.sample == 16'sd0)
        else $error("flat sample not zero");
    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= 3'(MAX_PARTIALS)) else $error("too many active partials");
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max) else $error("min above max");

endmodule

@@ verif/tb_additive_sine_synth_normalizer_core.sv @@
module tb_additive_sine_synth_normalizer_core;
    import assn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = 1024;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [59:0] i_cfg_data;

    additive_sine_synth_normalizer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow of the registers and the synthesis state.
    logic [31:0]        fund_step_q;
    logic [59:0]        ratios_q;
    logic [59:0]        amps_q;
    logic [2:0]         count_q;
    logic [14:0]        peak_q;
    logic [31:0]        phase_q [MAX_PARTIALS];
    logic [31:0]        step_q [MAX_PARTIALS];
    int                 active_q;
    int                 min_q;
    int                 max_q;
    longint             range_q;
    logic signed [15:0] sine_rom [TABLE_DEPTH];

    t_out sample_queue [$];
    int   error_count;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] sine_entry(input longint unsigned i);
        longint unsigned n4, q, rem, x, x2, t, s, mag;
        longint unsigned divs [6];
        divs = '{156, 110, 72, 42, 20, 6};
        n4  = 4 * i;
        q   = n4 / TABLE_DEPTH;
        rem = n4 % TABLE_DEPTH;
        if (q[0]) begin
            rem = TABLE_DEPTH - rem;
        end
        x  = (64'd1686629713 * rem) / TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int k = 0; k < 6; k++) begin
            t = (64'd1 << 30) - (((x2 * t) >> 30) / divs[k]);
        end
        s   = (x * t) >> 30;
        mag = (s * 32767 + (64'd1 << 29)) >> 30;
        if (mag > 32767) begin
            mag = 32767;
        end
        return (q >= 2) ? -16'(mag) : 16'(mag);
    endfunction

    function automatic longint unsigned ten_bits(input logic [59:0] r, input int n);
        return (r >> (10 * n)) & 60'h3FF;
    endfunction

    function automatic void load_steps();
        int               cnt;
        longint unsigned  full;
        cnt = (count_q > MAX_PARTIALS) ? MAX_PARTIALS : count_q;
        for (int n = 0; n < MAX_PARTIALS; n++) begin
            step_q[n] = '0;
        end
        active_q = 0;
        for (int n = 0; n < cnt; n++) begin
            full = longint'(fund_step_q) * ten_bits(ratios_q, n);
            if (full >= (64'd1 << 39)) begin
                break;
            end
            step_q[n] = 32'(full >> 8);
            active_q  = n + 1;
        end
    endfunction

    function automatic int partial_sum();
        longint acc;
        longint x;
        acc = 0;
        for (int n = 0; n < active_q; n++) begin
            acc += longint'(ten_bits(amps_q, n)) * sine_rom[phase_q[n][31:22]];
            phase_q[n] = phase_q[n] + step_q[n];
        end
        x = (acc >= 0) ? acc / 512 : -((-acc + 511) / 512);
        if (x > 524287) begin
            x = 524287;
        end
        if (x < -524288) begin
            x = -524288;
        end
        return int'(x);
    endfunction

    // Advances the shadow state by one tick and queues the sample an emit tick returns.
    function automatic void predict_tick(input t_in item);
        int     x;
        longint y;
        t_out   res;
        if (item.restart) begin
            for (int n = 0; n < MAX_PARTIALS; n++) begin
                phase_q[n] = '0;
            end
            if (item.pass_sel) begin
                range_q = longint'(max_q) - longint'(min_q);
            end else begin
                load_steps();
            end
        end
        x = partial_sum();
        if (!item.pass_sel) begin
            if (item.restart) begin
                min_q = x;
                max_q = x;
            end else begin
                if (x > max_q) max_q = x;
                if (x < min_q) min_q = x;
            end
            return;
        end
        if (range_q <= 0) begin
            res.sample = '0;
            res.flat   = 1'b1;
        end else begin
            y = longint'(peak_q) * (2 * (longint'(x) - min_q) - range_q) / range_q;
            if (y > 32767) y = 32767;
            if (y < -32767) y = -32767;
            res.sample = 16'(y);
            res.flat   = 1'b0;
        end
        sample_queue.push_back(res);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sample_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d", o_out_data.sample));
            end else begin
                want = sample_queue.pop_front();
                if (o_out_data.sample !== want.sample) begin
                    report_mismatch($sformatf("sample %0d, expected %0d",
                                              o_out_data.sample, want.sample));
                end
                if (o_out_data.flat !== want.flat) begin
                    report_mismatch($sformatf("flat %0b, expected %0b",
                                              o_out_data.flat, want.flat));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Ends the run when nothing has been accepted for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_tick(input logic pass_sel, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_data.pass_sel  <= pass_sel;
        i_in_data.restart   <= restart;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_tick('{pass_sel: pass_sel, restart: restart});
        i_in_valid <= 1'b0;
        // The block is busy after accepting an item, so this edge costs nothing.
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sample_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [59:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        case (index)
            REG_FUND_STEP: fund_step_q = value[31:0];
            REG_RATIOS:    ratios_q    = value;
            REG_AMPS:      amps_q      = value;
            REG_COUNT:     count_q     = value[2:0];
            REG_PEAK:      peak_q      = value[14:0];
            default: ;
        endcase
    endtask

    // One measure pass and one emit pass over the same number of ticks.
    task automatic run_passes(input int len);
        send_tick(1'b0, 1'b1);
        for (int i = 1; i < len; i++) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        for (int i = 1; i < len; i++) send_tick(1'b1, 1'b0);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Before any restart the range is zero, so the sample is flat.
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        run_passes(8);
        // Zero partials give a flat signal.
        write_reg(REG_COUNT, 60'd0);
        run_passes(2);
        // Nyquist cut on partial 0 and a count above the limit.
        write_reg(REG_COUNT, 60'd7);
        write_reg(REG_FUND_STEP, 60'hFFFF_FFFF);
        run_passes(2);
    endtask

    task automatic test_extremes();
        write_reg(REG_FUND_STEP, 60'd30000000);
        write_reg(REG_RATIOS, {60{1'b1}});
        write_reg(REG_AMPS, {60{1'b1}});
        write_reg(REG_PEAK, 60'h7FFF);
        run_passes(10);
        write_reg(REG_PEAK, 60'd0);
        run_passes(4);
        write_reg(REG_RATIOS, 60'd0);
        write_reg(REG_FUND_STEP, 60'd0);
        write_reg(REG_PEAK, 60'd1);
        run_passes(3);
    endtask

    // Random settings, with a config change between passes that drives saturation.
    task automatic test_random(input int items, input int s_pct, input int r_pct);
        int sent;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        sent = 0;
        while (sent < items) begin
            write_reg(REG_FUND_STEP, {28'd0, $urandom()} >> $urandom_range(8));
            write_reg(REG_RATIOS, 60'({$urandom(), $urandom()}));
            write_reg(REG_AMPS, 60'({$urandom(), $urandom()}));
            write_reg(REG_COUNT, 60'($urandom_range(7)));
            write_reg(REG_PEAK, 60'($urandom_range(32767)));
            if ($urandom_range(9) == 0) begin
                send_tick(1'b0, 1'b1);
                for (int i = 0; i < 5; i++) send_tick(1'b0, 1'b0);
                write_reg(REG_AMPS, 60'({$urandom(), $urandom()}));
                for (int i = 0; i < 6; i++) send_tick(1'b1, i == 0);
                sent += 12;
            end else if ($urandom_range(5) == 0) begin
                for (int i = 0; i < 10; i++) begin
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                sent += 10;
            end else begin
                run_passes($urandom_range(2, 8));
                sent += 10;
            end
        end
    endtask

    initial begin
        error_count    = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        fund_step_q    = 32'd42852282;
        ratios_q       = 60'd649081777758211328;
        amps_q         = 60'd537395712;
        count_q        = 3'd6;
        peak_q         = 15'd22334;
        for (int n = 0; n < MAX_PARTIALS; n++) begin
            phase_q[n] = '0;
            step_q[n]  = '0;
        end
        active_q = 0;
        min_q    = 0;
        max_q    = 0;
        range_q  = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            sine_rom[i] = sine_entry(i);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extremes();
        test_random(130, 0, 0);
        test_random(120, 46, 0);
        test_random(120, 0, 46);
        test_random(130, 38, 38);
        drain();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
